/* rtl/mnt_pkg.sv */
// ----------------------------------------------------------------------------
// mnt_pkg
// Types, constants and helpers shared by the neighbor table modules.
// ----------------------------------------------------------------------------
package mnt_pkg;

    localparam int unsigned ENTRIES_DEFAULT = 32;
    localparam int unsigned TIME_W          = 17;
    localparam int unsigned DAY_SECONDS     = 86400;
    localparam logic [TIME_W-1:0] MISSING_RESET = TIME_W'(30 * 60);
    localparam logic [TIME_W-1:0] LOST_RESET    = TIME_W'(60 * 60);
    localparam logic [31:0] SEQ_REBOOT  = 32'hFFFF_FFFF;
    localparam logic [15:0] ADDR_ANY    = 16'hFFFF;
    localparam logic [8:0]  RSSI_OFFSET = 9'd161;

    localparam logic [1:0] ACT_BEACON = 2'd0;
    localparam logic [1:0] ACT_DATA   = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [1:0] ST_UNUSED = 2'd0;
    localparam logic [1:0] ST_VALID  = 2'd1;
    localparam logic [1:0] ST_LOST   = 2'd2;

    localparam logic [0:0] REG_MISSING = 1'd0;
    localparam logic [0:0] REG_LOST    = 1'd1;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] callsign;
        logic [15:0] node_addr;
        logic [31:0] seq_num;
        logic [7:0]  rssi_raw;
        logic [7:0]  frame_flags;
    } t_in_word;

    typedef struct packed {
        logic       accept;
        logic       found;
        logic       added;
        logic       dropped_full;
        logic [4:0] entry_index;
    } t_out_word;

    // one table row in memory (status lives in flip-flops)
    typedef struct packed {
        logic [31:0]       callsign;
        logic [15:0]       addr;
        logic [31:0]       next_seq;
        logic [8:0]        rssi_dbm;
        logic [TIME_W-1:0] stamp;
        logic [7:0]        flags;
    } t_row;

    localparam int unsigned ROW_W = $bits(t_row);

    function automatic logic [31:0] seq_after(input logic [31:0] seq);
        return (seq == SEQ_REBOOT) ? 32'd0 : seq + 32'd1;
    endfunction

    function automatic logic [8:0] rssi_to_dbm(input logic [7:0] raw);
        return {2'b00, raw[7:1]} - RSSI_OFFSET;
    endfunction

    // (now - stamp) mod day, both below a day
    function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] now,
                                                  input logic [TIME_W-1:0] stamp);
        logic [TIME_W:0] d;
        d = {1'b0, now} - {1'b0, stamp};
        if (d[TIME_W]) d = d + (TIME_W+1)'(DAY_SECONDS);
        return d[TIME_W-1:0];
    endfunction

    typedef struct packed {
        logic start;     // latch input word, clear scan index
        logic step;      // advance scan index
        logic rd;        // row read at scan index (not used by the datapath)
        logic chk;       // evaluate row returned by memory
        logic finish;    // perform update, load result
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic scan_end;   // scan index reached fill count, or action unknown
        logic hit;        // match seen on current row
    } t_sts;

endpackage

/* rtl/mnt_ram.sv */
// ----------------------------------------------------------------------------
// mnt_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mnt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/mnt_ctrl.sv */
// ----------------------------------------------------------------------------
// mnt_ctrl
// Sequencer: accept word, scan rows, update, hold result.
// ----------------------------------------------------------------------------
module mnt_ctrl import mnt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_RD;
                end
            end
            S_RD: begin
                if (i_sts.scan_end) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_WAIT;
                end
            end
            S_WAIT: n_state = S_CHK;
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.hit && !i_sts.is_tick) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

/* rtl/mnt_dp.sv */
// ----------------------------------------------------------------------------
// mnt_dp
// Datapath: status flags, row memory, clock, limits, match and aging.
// ----------------------------------------------------------------------------
module mnt_dp import mnt_pkg::*; #(
    parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_word          i_in,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [TIME_W-1:0] i_cfg_data,
    output logic [TIME_W-1:0] o_missing,
    output logic [TIME_W-1:0] o_lost,
    output t_out_word         o_out
);
    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    logic [1:0]        r_status [ENTRIES];
    logic [CW-1:0]     r_fill;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_missing, r_lost;
    t_in_word          r_in;
    logic [CW-1:0]     r_idx;
    logic              r_hit;
    logic [IW-1:0]     r_hit_idx;
    t_row              r_hit_row;
    t_out_word         r_out, n_out;

    t_row          w_rd_row, w_wr_row;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [IW-1:0] w_cur;
    logic [1:0]    w_st;
    logic          w_match;
    logic [TIME_W-1:0] w_el;
    logic          w_full;

    assign w_cur = r_idx[IW-1:0];
    assign w_st  = r_status[w_cur];
    assign w_full = (r_fill == CW'(ENTRIES));

    assign w_match = (w_st == ST_VALID || w_st == ST_LOST)
                   && (w_rd_row.callsign == r_in.callsign)
                   && (r_in.node_addr == ADDR_ANY || w_rd_row.addr == r_in.node_addr);
    assign w_el = elapsed(r_now, w_rd_row.stamp);

    assign o_sts.is_tick  = (r_in.action == ACT_TICK);
    assign o_sts.scan_end = (r_idx >= r_fill) || !(r_in.action == ACT_BEACON
                           || r_in.action == ACT_DATA || r_in.action == ACT_TICK);
    assign o_sts.hit      = w_match;

    // write-back on finish
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_hit_idx;
        w_wr_row = r_hit_row;
        if (i_cmd.finish && (r_in.action == ACT_BEACON || r_in.action == ACT_DATA)) begin
            if (r_hit) begin
                if (r_in.action == ACT_BEACON) begin
                    w_we              = 1'b1;
                    w_wr_row.stamp    = r_now;
                    w_wr_row.rssi_dbm = rssi_to_dbm(r_in.rssi_raw);
                    w_wr_row.next_seq = seq_after(r_in.seq_num);
                end else if (r_in.seq_num == SEQ_REBOOT
                             || r_in.seq_num >= r_hit_row.next_seq) begin
                    w_we              = 1'b1;
                    w_wr_row.next_seq = seq_after(r_in.seq_num);
                end
            end else if (!w_full) begin
                w_we     = 1'b1;
                w_waddr  = r_fill[IW-1:0];
                w_wr_row = '{callsign: r_in.callsign, addr: r_in.node_addr,
                             next_seq: seq_after(r_in.seq_num),
                             rssi_dbm: rssi_to_dbm(r_in.rssi_raw),
                             stamp: r_now, flags: r_in.frame_flags};
            end
        end
    end

    // result word loaded on finish
    always_comb begin
        n_out = '{accept: 1'b1, found: 1'b0, added: 1'b0,
                  dropped_full: 1'b0, entry_index: 5'd0};
        if (r_in.action == ACT_BEACON || r_in.action == ACT_DATA) begin
            if (r_hit) begin
                n_out.found       = 1'b1;
                n_out.entry_index = 5'(r_hit_idx);
                if (r_in.action == ACT_DATA && r_in.seq_num != SEQ_REBOOT
                    && r_in.seq_num < r_hit_row.next_seq) n_out.accept = 1'b0;
            end else if (w_full) begin
                n_out.dropped_full = 1'b1;
            end else begin
                n_out.added       = 1'b1;
                n_out.entry_index = 5'(r_fill);
            end
        end
    end

    mnt_ram #(.WIDTH(ROW_W), .DEPTH(ENTRIES)) u_rows (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wr_row),
        .i_raddr (w_cur),
        .o_rdata (w_rd_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_now     <= '0;
            r_missing <= MISSING_RESET;
            r_lost    <= LOST_RESET;
            for (int i = 0; i < ENTRIES; i++) r_status[i] <= ST_UNUSED;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MISSING) r_missing <= i_cfg_data;
                else                          r_lost    <= i_cfg_data;
            end
            if (i_cmd.start && i_in.action == ACT_TICK) begin
                r_now <= (r_now == TIME_W'(DAY_SECONDS - 1)) ? '0 : r_now + 1'b1;
            end
            if (i_cmd.chk && r_in.action == ACT_TICK) begin
                if (w_st == ST_VALID && w_el > r_missing) r_status[w_cur] <= ST_LOST;
                else if (w_st == ST_LOST && w_el > r_lost) r_status[w_cur] <= ST_UNUSED;
            end
            // sender check leaves status alone; beacon and append mark valid
            if (i_cmd.finish && w_we && (r_in.action == ACT_BEACON || !r_hit)) begin
                r_status[w_waddr] <= ST_VALID;
            end
            if (i_cmd.finish && w_we && !r_hit) r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_in  <= i_in;
            r_idx <= '0;
            r_hit <= 1'b0;
        end
        if (i_cmd.step) r_idx <= r_idx + 1'b1;
        if (i_cmd.chk && w_match && r_in.action != ACT_TICK) begin
            r_hit     <= 1'b1;
            r_hit_idx <= w_cur;
            r_hit_row <= w_rd_row;
        end
        if (i_cmd.finish) r_out <= n_out;
    end

    assign o_missing = r_missing;
    assign o_lost    = r_lost;
    assign o_out     = r_out;
endmodule

/* rtl/mesh_neighbor_table.sv */
// ----------------------------------------------------------------------------
// mesh_neighbor_table
// Neighbor table with sequence-number duplicate filter and daily aging.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | word
// in      | input     | i_in_valid/o_in_stall  | t_in_word
// out     | output    | o_out_valid/i_out_stall | t_out_word
// cfg     | input     | APB psel/penable   | limits, 17 bit
//
// Scan: a result is valid once the rows up to the fill count are scanned and
// the update is done; beacon and data stop at the first hit.
// The next word can be taken in the cycle after the result leaves.
// The scan is set by the single read port of the row memory (registered read).
// Reset: synchronous, active low; clears status flags, fill count and clock,
// loads default limits.
// A new word is taken only once the previous result has left the output.
// ----------------------------------------------------------------------------
module mesh_neighbor_table import mnt_pkg::*; #(
    parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cmd w_cmd;
    t_sts w_sts;
    logic [TIME_W-1:0] w_missing, w_lost;
    logic w_cfg_we;

    assign pready   = 1'b1;
    // registers at 0 and 4; bit 2 selects
    assign w_cfg_we = psel && penable && pwrite && (paddr[1:0] == 2'd0) && !paddr[2]
                    || psel && penable && pwrite && (paddr == 3'd4);
    assign prdata   = (paddr == 3'd0) ? {15'd0, w_missing}
                    : (paddr == 3'd4) ? {15'd0, w_lost} : 32'd0;

    mnt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mnt_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in_word),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (w_cfg_we),
        .i_cfg_idx  (paddr[2]),
        .i_cfg_data (pwdata[TIME_W-1:0]),
        .o_missing  (w_missing),
        .o_lost     (w_lost),
        .o_out      (o_out_word)
    );
endmodule

/* rtl/mnt_checker.sv */
// ----------------------------------------------------------------------------
// mnt_checker
// Port-level checks of the neighbor table.
// ----------------------------------------------------------------------------
module mnt_checker import mnt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid)
        else $error("stalled input dropped");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_out_word.found, o_out_word.added,
                                    o_out_word.dropped_full}) <= 1)
        else $error("result flags overlap");

    a_reject_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.accept |-> o_out_word.found)
        else $error("reject without match");
endmodule

bind mesh_neighbor_table mnt_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

/* verif/mesh_neighbor_table_tb.sv */
// ----------------------------------------------------------------------------
// mesh_neighbor_table_tb
// Self-checking bench for the neighbor table: beacons, sender checks and
// ticks go in under random gaps and stalls, and a shadow table predicts each
// result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mesh_neighbor_table_tb;
    import mnt_pkg::*;

    localparam int unsigned NROWS      = 32;
    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned N_RANDOM   = 1420;

    // Shadow of the table plus the queue of predicted result words.
    class nbr_scoreboard;
        logic [1:0]  row_state [NROWS];
        logic [31:0] row_call  [NROWS];
        logic [15:0] row_addr  [NROWS];
        logic [31:0] row_next  [NROWS];
        logic [16:0] row_stamp [NROWS];
        int unsigned rows_used;
        logic [16:0] clock_sec;
        logic [16:0] missing_lim;
        logic [16:0] lost_lim;
        t_out_word   pending [$];
        int unsigned errors;
        int unsigned n_hits, n_adds, n_drops, n_rejects, n_ticks;

        function void clear();
            foreach (row_state[i]) row_state[i] = ST_UNUSED;
            rows_used   = 0;
            clock_sec   = '0;
            missing_lim = MISSING_RESET;
            lost_lim    = LOST_RESET;
        endfunction

        function logic [16:0] age_of(logic [16:0] stamp);
            int unsigned d;
            d = (int'(clock_sec) + 86400 - int'(stamp)) % 86400;
            return d[16:0];
        endfunction

        function void note_input(t_in_word w);
            t_out_word r;
            int hit;
            r = '0;
            r.accept = 1'b1;
            hit = -1;
            if (w.action == ACT_BEACON || w.action == ACT_DATA) begin
                for (int i = 0; i < int'(rows_used); i++) begin
                    if (hit < 0 && row_state[i] != ST_UNUSED && row_call[i] == w.callsign &&
                        (w.node_addr == ADDR_ANY || row_addr[i] == w.node_addr)) begin
                        hit = i;
                    end
                end
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.entry_index = hit[4:0];
                    n_hits++;
                    if (w.action == ACT_BEACON) begin
                        row_stamp[hit] = clock_sec;
                        row_next[hit]  = (w.seq_num == SEQ_REBOOT) ? '0 : w.seq_num + 32'd1;
                        row_state[hit] = ST_VALID;
                    end else if (w.seq_num == SEQ_REBOOT) begin
                        row_next[hit] = '0;
                    end else if (w.seq_num < row_next[hit]) begin
                        r.accept = 1'b0;
                        n_rejects++;
                    end else begin
                        row_next[hit] = w.seq_num + 32'd1;
                    end
                end else if (rows_used >= NROWS) begin
                    r.dropped_full = 1'b1;
                    n_drops++;
                end else begin
                    row_state[rows_used] = ST_VALID;
                    row_call[rows_used]  = w.callsign;
                    row_addr[rows_used]  = w.node_addr;
                    row_next[rows_used]  = (w.seq_num == SEQ_REBOOT) ? '0 : w.seq_num + 32'd1;
                    row_stamp[rows_used] = clock_sec;
                    r.added = 1'b1;
                    r.entry_index = rows_used[4:0];
                    rows_used++;
                    n_adds++;
                end
            end else if (w.action == ACT_TICK) begin
                n_ticks++;
                clock_sec = (clock_sec == 17'd86399) ? '0 : clock_sec + 17'd1;
                for (int i = 0; i < int'(rows_used); i++) begin
                    if (row_state[i] == ST_VALID) begin
                        if (age_of(row_stamp[i]) > missing_lim) row_state[i] = ST_LOST;
                    end else if (row_state[i] == ST_LOST) begin
                        if (age_of(row_stamp[i]) > lost_lim) row_state[i] = ST_UNUSED;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.accept !== want.accept) begin
                $display("%0t: accept exp %0b got %0b", $time, want.accept, got.accept);
                errors++;
            end
            if (got.found !== want.found) begin
                $display("%0t: found exp %0b got %0b", $time, want.found, got.found);
                errors++;
            end
            if (got.added !== want.added) begin
                $display("%0t: added exp %0b got %0b", $time, want.added, got.added);
                errors++;
            end
            if (got.dropped_full !== want.dropped_full) begin
                $display("%0t: dropped_full exp %0b got %0b", $time,
                         want.dropped_full, got.dropped_full);
                errors++;
            end
            if (got.entry_index !== want.entry_index) begin
                $display("%0t: entry_index exp %0d got %0d", $time,
                         want.entry_index, got.entry_index);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_word;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nbr_scoreboard nbr_sb;
    int unsigned   idle_cycles;
    bit            stall_enable;

    mesh_neighbor_table DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Random gap length: mostly short, now and then long.
    function automatic int unsigned gap_len();
        if ($urandom_range(9) == 0) return $urandom_range(60, 10);
        if ($urandom_range(2) == 0) return 0;
        return $urandom_range(3);
    endfunction

    // Receiver side: check accepted words, stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) nbr_sb.check_result(o_out_word);
        end
        i_out_stall <= stall_enable ? ($urandom_range(3) == 0) : 1'b0;
    end

    // Watchdog: consecutive cycles with no word moving on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Send one word, then an optional random gap.
    task automatic send_word(input t_in_word w, input bit with_gap);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        nbr_sb.note_input(w);
        if (with_gap) begin
            int unsigned g;
            g = gap_len();
            if (g > 0) begin
                i_in_valid <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    endtask

    task automatic go_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (nbr_sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // APB write: setup cycle then access cycle.
    task automatic reg_write(input logic [0:0] idx, input logic [16:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {15'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MISSING) nbr_sb.missing_lim = value;
        else nbr_sb.lost_lim = value;
    endtask

    function automatic t_in_word mk(logic [1:0] act, logic [31:0] call, logic [15:0] addr,
                                    logic [31:0] seq);
        t_in_word w;
        w.action      = act;
        w.callsign    = call;
        w.node_addr   = addr;
        w.seq_num     = seq;
        w.rssi_raw    = 8'($urandom());
        w.frame_flags = 8'($urandom());
        return w;
    endfunction

    // Callsigns come from a small pool so that lookups hit often.
    function automatic t_in_word rand_word(int unsigned pool);
        t_in_word w;
        int unsigned k, p;
        logic [1:0] act;
        p = $urandom_range(99);
        if (p < 40) act = ACT_BEACON;
        else if (p < 75) act = ACT_DATA;
        else if (p < 98) act = ACT_TICK;
        else act = 2'd3;
        k = $urandom_range(pool - 1);
        w = mk(act, 32'hA5000000 ^ (k * 32'h01010101), 16'(k * 7), $urandom_range(40));
        case ($urandom_range(9))
            0: w.callsign = $urandom();
            1: w.node_addr = ADDR_ANY;
            2: w.node_addr = 16'($urandom());
            3: w.seq_num = $urandom();
            4: w.seq_num = SEQ_REBOOT;
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        nbr_sb = new();
        nbr_sb.clear();
        nbr_sb.errors = 0;
        idle_cycles = 0;
        stall_enable = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short limits so aging shows up within a few ticks.
        reg_write(REG_MISSING, 17'd2);
        reg_write(REG_LOST, 17'd3);

        // Directed: field extremes, every action, reboot, duplicate, wildcard.
        send_word(mk(ACT_BEACON, 32'h0, 16'h0, 32'h0), 1'b0);
        send_word(mk(ACT_BEACON, 32'hFFFFFFFF, 16'hFFFE, SEQ_REBOOT), 1'b0);
        send_word(mk(ACT_DATA, 32'h0, 16'h0, 32'h0), 1'b0);
        send_word(mk(ACT_DATA, 32'h0, 16'h0, 32'h5), 1'b0);
        send_word(mk(ACT_DATA, 32'h0, 16'h0, 32'h3), 1'b0);
        send_word(mk(ACT_DATA, 32'h0, ADDR_ANY, SEQ_REBOOT), 1'b0);
        send_word(mk(ACT_DATA, 32'hFFFFFFFF, ADDR_ANY, 32'hFFFFFFFE), 1'b0);
        send_word(mk(ACT_DATA, 32'h12345678, ADDR_ANY, 32'h10), 1'b0);
        send_word(mk(2'd3, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF), 1'b0);
        send_word(mk(ACT_BEACON, 32'h0, 16'h0, 32'h7), 1'b0);
        for (int i = 0; i < 6; i++) send_word(mk(ACT_TICK, 32'h0, 16'h0, 32'h0), 1'b0);
        send_word(mk(ACT_DATA, 32'h0, 16'h0, 32'h8), 1'b0);
        send_word(mk(ACT_BEACON, 32'hFFFFFFFF, 16'hFFFE, 32'h1), 1'b0);
        // Everything stays valid with the largest limits.
        go_idle();
        reg_write(REG_MISSING, 17'd86399);
        reg_write(REG_LOST, 17'd86399);

        // Random: phases with different limits; the table fills up early
        // since slots are never reused, so later phases exercise the full path.
        stall_enable = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            int unsigned pool;
            pool = (ph < 2) ? 12 : 48;
            for (int n = 0; n < int'(N_RANDOM / 6); n++) begin
                send_word(rand_word(pool), (ph % 3) != 1);
            end
            go_idle();
            case (ph)
                0: begin reg_write(REG_MISSING, 17'd0); reg_write(REG_LOST, 17'd0); end
                1: begin reg_write(REG_MISSING, 17'd5); reg_write(REG_LOST, 17'd20); end
                2: begin reg_write(REG_MISSING, 17'd86399); reg_write(REG_LOST, 17'd1); end
                3: begin reg_write(REG_MISSING, 17'd1800); reg_write(REG_LOST, 17'd3600); end
                default: begin reg_write(REG_MISSING, 17'd3); reg_write(REG_LOST, 17'd86399); end
            endcase
        end

        go_idle();
        $display("Covered %0d hits, %0d appends, %0d drops on a full table,",
                 nbr_sb.n_hits, nbr_sb.n_adds, nbr_sb.n_drops);
        $display("%0d duplicate rejects and %0d ticks under six limit settings.",
                 nbr_sb.n_rejects, nbr_sb.n_ticks);
        if (nbr_sb.errors == 0 && nbr_sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/mnt_pkg.sv
rtl/mnt_ram.sv
rtl/mnt_ctrl.sv
rtl/mnt_dp.sv
rtl/mesh_neighbor_table.sv
rtl/mnt_checker.sv
verif/mesh_neighbor_table_tb.sv
